// File: hw/rtl/obl_pkg.sv
// Shared types and constants for the order book level update block.
`timescale 1ns / 1ps
`default_nettype none

package obl_pkg;

	// Field widths of the request and result items
	localparam int SLOT_W   = 2;
	localparam int PRICE_W  = 32;
	localparam int QTYIN_W  = 32;
	localparam int QTY_W    = 31;
	localparam int ACT_W    = 3;
	localparam int CNTOUT_W = 5;
	localparam int SCAN_W   = 7;

	// Result action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_REPLACED = 3'd0,
		ACT_REMOVED  = 3'd1,
		ACT_INSERTED = 3'd2,
		ACT_IGNORED  = 3'd3,
		ACT_DROPPED  = 3'd4
	} action_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_WRITE,
		ST_BEST,
		ST_RESULT
	} state_t;

	// Outcome of the shared price compare unit
	typedef struct packed {
		logic eq;
		logic ahead;
	} cmp_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/obl_if.sv
// Request and result channel interfaces of the order book level update block.
`timescale 1ns / 1ps
`default_nettype none

interface obl_req_if;
	logic                              valid;
	logic                              ready;
	logic [obl_pkg::SLOT_W-1:0]        market_slot;
	logic                              side;
	logic [obl_pkg::PRICE_W-1:0]       level_price;
	logic signed [obl_pkg::QTYIN_W-1:0] level_quantity;

	modport source (output valid, market_slot, side, level_price, level_quantity,
		input ready);
	modport sink (input valid, market_slot, side, level_price, level_quantity,
		output ready);
endinterface

interface obl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [obl_pkg::ACT_W-1:0]     action;
	logic [obl_pkg::CNTOUT_W-1:0]  level_count;
	logic [obl_pkg::PRICE_W-1:0]   best_price;
	logic [obl_pkg::QTY_W-1:0]     best_quantity;

	modport source (output valid, action, level_count, best_price, best_quantity,
		input ready);
	modport sink (input valid, action, level_count, best_price, best_quantity,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/obl_ram.sv
// Book level storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module obl_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 63
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry, hold the last data otherwise
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/obl_cmp.sv
// Shared price compare unit: equality and sort-order test against a stored level.
`timescale 1ns / 1ps
`default_nettype none

module obl_cmp (
	input  wire logic [obl_pkg::PRICE_W-1:0] new_price,
	input  wire logic [obl_pkg::PRICE_W-1:0] lvl_price,
	input  wire logic                        bid,
	output obl_pkg::cmp_res_t                res
);

	// Bids sort descending, asks ascending
	always_comb begin
		res.eq    = (new_price == lvl_price);
		res.ahead = bid ? (new_price > lvl_price) : (new_price < lvl_price);
	end

endmodule

`default_nettype wire

// File: hw/rtl/obl_ctrl.sv
// Update sequencer: scans a side, shifts levels, writes the entry and reads the best level.
`timescale 1ns / 1ps
`default_nettype none

module obl_ctrl #(
	parameter int MARKETS = 4,
	parameter int LEVELS  = 16,
	localparam int MW = (MARKETS > 1) ? $clog2(MARKETS) : 1,
	localparam int SW = MW + 1,
	localparam int IW = $clog2(LEVELS),
	localparam int CW = $clog2(LEVELS + 1),
	localparam int AW = $clog2(MARKETS * 2 * LEVELS),
	localparam int DW = obl_pkg::QTY_W + obl_pkg::PRICE_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	obl_req_if.sink            req,
	obl_rsp_if.source          rsp,
	// side count table
	output logic [SW-1:0]      cnt_ridx,
	input  wire logic [CW-1:0] cnt_rd,
	output logic               cnt_we,
	output logic [SW-1:0]      cnt_widx,
	output logic [CW-1:0]      cnt_wval,
	// level storage
	output logic               ram_wr_en,
	output logic [AW-1:0]      ram_wr_addr,
	output logic [DW-1:0]      ram_wr_data,
	output logic               ram_rd_en,
	output logic [AW-1:0]      ram_rd_addr,
	input  wire logic [DW-1:0] ram_rd_data
);

	localparam int PW = obl_pkg::PRICE_W;
	localparam int QW = obl_pkg::QTY_W;

	obl_pkg::state_t   state_q, state_d;
	obl_pkg::cmp_res_t cmp;
	obl_pkg::action_t  act_d, act_q;

	logic [obl_pkg::SCAN_W-1:0] slot_red;
	logic [SW-1:0]  sidx_in;
	logic [SW-1:0]  sidx_q;
	logic [AW-1:0]  base_q;
	logic           bid_q;
	logic [PW-1:0]  price_q;
	logic [QW-1:0]  qty_q;
	logic           posv_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  iss_q;
	logic [CW-1:0]  cmp_q;
	logic           pend_q, pend_d;
	logic [CW-1:0]  hit_q;
	logic           eq_q;
	logic [CW-1:0]  ncnt_d, ncnt_q;
	logic [CW-1:0]  mv_d;
	logic           up_q;
	logic [CW-1:0]  src_q;
	logic [CW-1:0]  dst_q;
	logic [CW-1:0]  rem_q;
	logic           scan_hit, scan_end, scan_issue, full;
	logic           accept, load_out;
	logic [CW-1:0]  rd_idx, wr_idx;

	logic                           ovalid_q;
	obl_pkg::action_t               out_act_q;
	logic [obl_pkg::CNTOUT_W-1:0]   out_cnt_q;
	logic [PW-1:0]                  out_price_q;
	logic [QW-1:0]                  out_qty_q;

	// Reduce the slot into the configured number of markets
	always_comb begin
		slot_red = obl_pkg::SCAN_W'(req.market_slot);
		for (int k = 0; k < 3; k++) begin
			if (slot_red >= obl_pkg::SCAN_W'(MARKETS)) begin
				slot_red = slot_red - obl_pkg::SCAN_W'(MARKETS);
			end
		end
	end

	assign sidx_in  = {slot_red[MW-1:0], req.side};
	assign cnt_ridx = sidx_in;

	// Shared compare of the request price against the level just read
	obl_cmp u_cmp (
		.new_price (price_q),
		.lvl_price (ram_rd_data[PW-1:0]),
		.bid       (bid_q),
		.res       (cmp)
	);

	assign scan_hit   = pend_q && (cmp.eq || cmp.ahead);
	assign scan_end   = !scan_hit && (iss_q == cnt_q);
	assign scan_issue = !scan_hit && (iss_q < cnt_q);
	assign full       = (cnt_q == CW'(LEVELS));
	assign accept     = (state_q == obl_pkg::ST_IDLE) && req.valid;
	assign load_out   = (state_q == obl_pkg::ST_RESULT) && (!ovalid_q || rsp.ready);

	// Classify the update once the scan has settled
	always_comb begin
		if (eq_q) begin
			act_d = posv_q ? obl_pkg::ACT_REPLACED : obl_pkg::ACT_REMOVED;
			mv_d  = cnt_q - hit_q - CW'(1);
		end else begin
			mv_d = cnt_q - hit_q;
			if (!posv_q) begin
				act_d = obl_pkg::ACT_IGNORED;
			end else if (full) begin
				act_d = obl_pkg::ACT_DROPPED;
			end else begin
				act_d = obl_pkg::ACT_INSERTED;
			end
		end
		case (act_d)
			obl_pkg::ACT_REMOVED:  ncnt_d = cnt_q - CW'(1);
			obl_pkg::ACT_INSERTED: ncnt_d = cnt_q + CW'(1);
			default:               ncnt_d = cnt_q;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			obl_pkg::ST_IDLE: begin
				if (req.valid) state_d = obl_pkg::ST_SCAN;
			end
			obl_pkg::ST_SCAN: begin
				if (scan_hit || scan_end) state_d = obl_pkg::ST_DECIDE;
			end
			obl_pkg::ST_DECIDE: begin
				case (act_d)
					obl_pkg::ACT_REPLACED: state_d = obl_pkg::ST_WRITE;
					obl_pkg::ACT_REMOVED:
						state_d = (mv_d != '0) ? obl_pkg::ST_SHIFT : obl_pkg::ST_BEST;
					obl_pkg::ACT_INSERTED:
						state_d = (mv_d != '0) ? obl_pkg::ST_SHIFT : obl_pkg::ST_WRITE;
					default: state_d = obl_pkg::ST_BEST;
				endcase
			end
			obl_pkg::ST_SHIFT: begin
				if (rem_q == '0) state_d = up_q ? obl_pkg::ST_WRITE : obl_pkg::ST_BEST;
			end
			obl_pkg::ST_WRITE:  state_d = obl_pkg::ST_BEST;
			obl_pkg::ST_BEST:   state_d = obl_pkg::ST_RESULT;
			obl_pkg::ST_RESULT: begin
				if (!ovalid_q || rsp.ready) state_d = obl_pkg::ST_IDLE;
			end
			default: state_d = obl_pkg::ST_IDLE;
		endcase
	end

	// Storage and count table controls
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		rd_idx      = '0;
		wr_idx      = hit_q;
		ram_wr_data = {qty_q, price_q};
		cnt_we      = 1'b0;
		pend_d      = 1'b0;
		case (state_q)
			obl_pkg::ST_SCAN: begin
				rd_idx    = iss_q;
				ram_rd_en = scan_issue;
				pend_d    = scan_issue;
			end
			obl_pkg::ST_DECIDE: begin
				cnt_we = 1'b1;
			end
			obl_pkg::ST_SHIFT: begin
				rd_idx      = src_q;
				ram_rd_en   = (rem_q != '0);
				pend_d      = (rem_q != '0);
				wr_idx      = dst_q;
				ram_wr_en   = pend_q;
				ram_wr_data = ram_rd_data;
			end
			obl_pkg::ST_WRITE: begin
				ram_wr_en = 1'b1;
			end
			obl_pkg::ST_BEST: begin
				ram_rd_en = 1'b1;
			end
			default: begin
				ram_rd_en = 1'b0;
			end
		endcase
	end

	assign ram_rd_addr = base_q + AW'(rd_idx[IW-1:0]);
	assign ram_wr_addr = base_q + AW'(wr_idx[IW-1:0]);
	assign cnt_widx    = sidx_q;
	assign cnt_wval    = ncnt_d;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= obl_pkg::ST_IDLE;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			obl_pkg::ST_IDLE: begin
				if (accept) begin
					sidx_q  <= sidx_in;
					base_q  <= AW'(sidx_in * LEVELS);
					bid_q   <= req.side;
					price_q <= req.level_price;
					qty_q   <= req.level_quantity[QW-1:0];
					posv_q  <= (req.level_quantity != '0) && !req.level_quantity[QW];
					cnt_q   <= cnt_rd;
					iss_q   <= '0;
				end
			end
			obl_pkg::ST_SCAN: begin
				if (scan_issue) begin
					cmp_q <= iss_q;
					iss_q <= iss_q + CW'(1);
				end
				if (scan_hit) begin
					hit_q <= cmp_q;
					eq_q  <= cmp.eq;
				end else if (scan_end) begin
					hit_q <= cnt_q;
					eq_q  <= 1'b0;
				end
			end
			obl_pkg::ST_DECIDE: begin
				act_q  <= act_d;
				ncnt_q <= ncnt_d;
				up_q   <= !eq_q;
				rem_q  <= mv_d;
				src_q  <= eq_q ? (hit_q + CW'(1)) : (cnt_q - CW'(1));
			end
			obl_pkg::ST_SHIFT: begin
				if (rem_q != '0) begin
					dst_q <= up_q ? (src_q + CW'(1)) : (src_q - CW'(1));
					src_q <= up_q ? (src_q - CW'(1)) : (src_q + CW'(1));
					rem_q <= rem_q - CW'(1);
				end
			end
			obl_pkg::ST_RESULT: begin
				if (load_out) begin
					out_act_q <= act_q;
					out_cnt_q <= obl_pkg::CNTOUT_W'(ncnt_q);
					if (ncnt_q != '0) begin
						out_price_q <= ram_rd_data[PW-1:0];
						out_qty_q   <= ram_rd_data[DW-1:PW];
					end else begin
						out_price_q <= '0;
						out_qty_q   <= '0;
					end
				end
			end
			default: begin
				eq_q <= eq_q;
			end
		endcase
	end

	assign req.ready         = (state_q == obl_pkg::ST_IDLE);
	assign rsp.valid         = ovalid_q;
	assign rsp.action        = out_act_q;
	assign rsp.level_count   = out_cnt_q;
	assign rsp.best_price    = out_price_q;
	assign rsp.best_quantity = out_qty_q;

endmodule

`default_nettype wire

// File: hw/rtl/order_book_level_update_top.sv
// Top level of the order book level update block: side count table, storage and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to LEVELS price levels per side for MARKETS market slots, asks ascending and
// bids descending, and applies one level update per request: replace, remove, insert,
// ignore or drop-when-full, returning the action, the side's level count and its best
// level. Requests are taken one at a time. The price scan stops at the matching level or
// at the first level the new price sorts ahead of, and the level shift moves only the
// levels behind that point, so scan and shift together walk the side about once, bounded
// by the single level storage read port, which serves one entry per cycle. A new request
// is accepted while the previous result is still waiting on the result channel; the block
// then holds in its result state until that result is taken. Level storage needs no
// clearing after reset; only the per-side counts are reset, so requests are taken from
// the first cycle after reset.
module order_book_level_update_top #(
	parameter int MARKETS = 4,
	parameter int LEVELS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	obl_req_if.sink   req,
	obl_rsp_if.source rsp
);

	localparam int MW    = (MARKETS > 1) ? $clog2(MARKETS) : 1;
	localparam int SW    = MW + 1;
	localparam int CW    = $clog2(LEVELS + 1);
	localparam int SIDES = MARKETS * 2;
	localparam int DEPTH = MARKETS * 2 * LEVELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = obl_pkg::QTY_W + obl_pkg::PRICE_W;

	logic [CW-1:0] cnt_q [SIDES];
	logic [SW-1:0] cnt_ridx, cnt_widx;
	logic [CW-1:0] cnt_rd, cnt_wval;
	logic          cnt_we;
	logic          ram_wr_en, ram_rd_en;
	logic [AW-1:0] ram_wr_addr, ram_rd_addr;
	logic [DW-1:0] ram_wr_data, ram_rd_data;

	// Hold the level count of every side; reset empties all books
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cnt_we) begin
			cnt_q[cnt_widx] <= cnt_wval;
		end
	end

	assign cnt_rd = cnt_q[cnt_ridx];

	obl_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	obl_ctrl #(
		.MARKETS (MARKETS),
		.LEVELS  (LEVELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cnt_ridx    (cnt_ridx),
		.cnt_rd      (cnt_rd),
		.cnt_we      (cnt_we),
		.cnt_widx    (cnt_widx),
		.cnt_wval    (cnt_wval),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

endmodule

`default_nettype wire

// File: tb/order_book_level_update_checker.sv
// Checker for the order book level update block: tracks the books and scores each result.
`timescale 1ns / 1ps

module order_book_level_update_checker #(
	parameter int MARKETS = 4,
	parameter int LEVELS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	obl_req_if   req,
	obl_rsp_if   rsp,
	output int   fail_count,
	output int   pending_count,
	output int   update_count,
	output int   action_tally [5]
);

	localparam int SIDES = MARKETS * 2;

	typedef struct packed {
		obl_pkg::action_t             action;
		logic [obl_pkg::CNTOUT_W-1:0] level_count;
		logic [obl_pkg::PRICE_W-1:0]  best_price;
		logic [obl_pkg::QTY_W-1:0]    best_quantity;
	} book_result_t;

	// Own copy of every side: prices, quantities and level counts
	logic [obl_pkg::PRICE_W-1:0] level_px  [SIDES][LEVELS];
	logic [obl_pkg::QTY_W-1:0]   level_qty [SIDES][LEVELS];
	int                          side_fill [SIDES];
	book_result_t                expected_results [$];

	// Apply one update to the book copy and return the result it must produce
	function automatic book_result_t apply_level_update(
		input logic [obl_pkg::SLOT_W-1:0] slot,
		input logic bid, input logic [obl_pkg::PRICE_W-1:0] price,
		input logic signed [obl_pkg::QTYIN_W-1:0] qty);
		int           sidx;
		int           cnt;
		int           hit;
		int           pos;
		book_result_t res;
		sidx = (int'(slot) % MARKETS) * 2 + int'(bid);
		cnt  = side_fill[sidx];
		hit  = -1;
		for (int i = 0; i < cnt; i++) begin
			if (hit < 0 && level_px[sidx][i] == price) begin
				hit = i;
			end
		end
		if (hit >= 0 && qty <= 0) begin
			// drop the level and close the gap behind it
			for (int i = hit; i < cnt - 1; i++) begin
				level_px[sidx][i]  = level_px[sidx][i + 1];
				level_qty[sidx][i] = level_qty[sidx][i + 1];
			end
			cnt--;
			res.action = obl_pkg::ACT_REMOVED;
		end else if (hit >= 0) begin
			level_qty[sidx][hit] = qty[obl_pkg::QTY_W-1:0];
			res.action = obl_pkg::ACT_REPLACED;
		end else if (qty <= 0) begin
			res.action = obl_pkg::ACT_IGNORED;
		end else if (cnt >= LEVELS) begin
			res.action = obl_pkg::ACT_DROPPED;
		end else begin
			// find the sorted slot: asks ascending, bids descending
			pos = cnt;
			for (int i = 0; i < cnt; i++) begin
				if (pos == cnt && (bid ? price > level_px[sidx][i] : price < level_px[sidx][i])) begin
					pos = i;
				end
			end
			for (int i = cnt; i > pos; i--) begin
				level_px[sidx][i]  = level_px[sidx][i - 1];
				level_qty[sidx][i] = level_qty[sidx][i - 1];
			end
			level_px[sidx][pos]  = price;
			level_qty[sidx][pos] = qty[obl_pkg::QTY_W-1:0];
			cnt++;
			res.action = obl_pkg::ACT_INSERTED;
		end
		side_fill[sidx]   = cnt;
		res.level_count   = obl_pkg::CNTOUT_W'(cnt);
		res.best_price    = (cnt > 0) ? level_px[sidx][0] : '0;
		res.best_quantity = (cnt > 0) ? level_qty[sidx][0] : '0;
		return res;
	endfunction

	// Score results against the oldest prediction, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		book_result_t want;
		if (!arst_n) begin
			for (int s = 0; s < SIDES; s++) begin
				side_fill[s] = 0;
			end
			expected_results.delete();
			pending_count <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no update waiting: action %0d", rsp.action);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, rsp.action);
						fail_count++;
					end
					if (rsp.level_count !== want.level_count) begin
						$error("level_count: expected %0d, got %0d", want.level_count,
							rsp.level_count);
						fail_count++;
					end
					if (rsp.best_price !== want.best_price) begin
						$error("best_price: expected %h, got %h", want.best_price,
							rsp.best_price);
						fail_count++;
					end
					if (rsp.best_quantity !== want.best_quantity) begin
						$error("best_quantity: expected %h, got %h", want.best_quantity,
							rsp.best_quantity);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = apply_level_update(req.market_slot, req.side, req.level_price,
					req.level_quantity);
				expected_results = {expected_results, want};
				action_tally[int'(want.action)]++;
				update_count++;
			end
			pending_count <= expected_results.size();
		end
	end

endmodule

// File: tb/order_book_level_update_top_test.sv
// Testbench top for the order book level update block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module order_book_level_update_top_test;

	localparam int MARKETS        = 4;
	localparam int LEVELS         = 16;
	localparam int RANDOM_UPDATES = 1900;
	localparam int PHASE_LEN      = 300;
	localparam int POOL_SIZE      = 20;
	localparam int TAIL_CYCLES    = 2 * LEVELS + 12;
	localparam int CYCLE_LIMIT    = 900000;

	logic clk        = 1'b0;
	logic arst_n     = 1'b0;
	logic sink_ready = 1'b0;
	int   gap_pct    = 8;
	int   stall_pct  = 8;
	int   cycle_count = 0;
	int   fail_count;
	int   pending_count;
	int   update_count;
	int   action_tally [5];
	logic [obl_pkg::PRICE_W-1:0] price_pool [POOL_SIZE];

	obl_req_if req_ch();
	obl_rsp_if rsp_ch();

	assign rsp_ch.ready = sink_ready;

	order_book_level_update_top #(
		.MARKETS(MARKETS),
		.LEVELS (LEVELS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	order_book_level_update_checker #(
		.MARKETS(MARKETS),
		.LEVELS (LEVELS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.update_count (update_count),
		.action_tally (action_tally)
	);

	always #6 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("order_book_level_update_top_test NOT OK");
			$finish;
		end
	end

	// Offer one update, idling first at random, and hold until it is taken
	task automatic send_update(input logic [obl_pkg::SLOT_W-1:0] slot, input logic bid,
		input logic [obl_pkg::PRICE_W-1:0] price,
		input logic signed [obl_pkg::QTYIN_W-1:0] qty);
		while ($urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.market_slot    <= slot;
		req_ch.side           <= bid;
		req_ch.level_price    <= price;
		req_ch.level_quantity <= qty;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int                                 r;
		logic                               fill_mode;
		logic [obl_pkg::PRICE_W-1:0]        price;
		logic signed [obl_pkg::QTYIN_W-1:0] qty;
		req_ch.valid          <= 1'b0;
		req_ch.market_slot    <= '0;
		req_ch.side           <= 1'b0;
		req_ch.level_price    <= '0;
		req_ch.level_quantity <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ask side of slot 0: price and quantity extremes, replace, remove, empty side
		send_update(2'd0, 1'b0, 32'h0000_0000, 32'sh7FFF_FFFF);
		send_update(2'd0, 1'b0, 32'hFFFF_FFFF, 32'sd1);
		send_update(2'd0, 1'b0, 32'h0000_0000, 32'sd5);
		send_update(2'd0, 1'b0, 32'hFFFF_FFFF, 32'sd0);
		send_update(2'd0, 1'b0, 32'h0000_0000, 32'sh8000_0000);
		send_update(2'd0, 1'b0, 32'h0000_0007, -32'sd1);

		// Bid side of slot 3: fill in scrambled order, then overflow and remove
		for (int k = 0; k < LEVELS; k++) begin
			send_update(2'd3, 1'b1, 32'h100 + 32'((k * 7) % LEVELS) * 32'h1000, 32'(k + 1));
		end
		send_update(2'd3, 1'b1, 32'hFFFF_FFFF, 32'sd9);
		send_update(2'd3, 1'b1, 32'h0000_0100, -32'sd1);
		hold_until_drained();

		// Shared price pool so updates hit existing levels often
		price_pool[0] = '0;
		price_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++) begin
			price_pool[k] = $urandom();
		end

		// Alternate fill-heavy and drain-heavy phases, with one calm stretch
		for (int k = 0; k < RANDOM_UPDATES; k++) begin
			fill_mode = ((k / PHASE_LEN) % 2 == 0);
			gap_pct   = (k >= 700 && k < 1000) ? 0 : 8;
			stall_pct = gap_pct;
			if (k == 450 || k == 1400) begin
				hold_until_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 85) begin
				price = price_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else if (r < 95) begin
				price = $urandom();
			end else begin
				price = $urandom_range(0, 1) ? '1 : '0;
			end
			r = $urandom_range(0, 99);
			if (r < (fill_mode ? 80 : 30)) begin
				case ($urandom_range(0, 9))
					0: begin
						qty = 32'sh7FFF_FFFF;
					end
					1: begin
						qty = 32'sd1;
					end
					2, 3, 4, 5: begin
						qty = $signed(32'($urandom_range(1, 1000)));
					end
					default: begin
						qty = $signed({1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))});
					end
				endcase
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						qty = 32'sd0;
					end
					1: begin
						qty = -32'sd1;
					end
					2: begin
						qty = 32'sh8000_0000;
					end
					default: begin
						qty = $signed({1'b1, 31'($urandom())});
					end
				endcase
			end
			send_update(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), price, qty);
		end

		// Drain, then watch for stray results
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Applied %0d updates to %0d slots on both sides, with idle and stall gaps.",
			update_count, MARKETS);
		$display("Outcomes: %0d inserted, %0d replaced, %0d removed, %0d ignored, %0d dropped.",
			action_tally[obl_pkg::ACT_INSERTED], action_tally[obl_pkg::ACT_REPLACED],
			action_tally[obl_pkg::ACT_REMOVED], action_tally[obl_pkg::ACT_IGNORED],
			action_tally[obl_pkg::ACT_DROPPED]);
		if (fail_count == 0 && pending_count == 0) begin
			$display("order_book_level_update_top_test OK");
		end else begin
			$display("order_book_level_update_top_test NOT OK");
		end
		$finish;
	end

endmodule
